// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is high
`define XCFR_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// clocked property that also holds during reset
`define XCFR_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// File: sv/xcfr_pkg.sv
// ----------------------------------------------------------------------------
// xcfr_pkg
// Shared types and constants of the XOR checked frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xcfr_pkg;

  localparam int MAX_FRAME_LEN_DEF = 64;

  localparam logic [7:0] PREAMBLE_RST = 8'hBD;
  localparam logic [7:0] CMD_LIMIT_RST = 8'h10;

  localparam logic [0:0] REG_PREAMBLE = 1'b0;
  localparam logic [0:0] REG_CMD_LIMIT = 1'b1;

  localparam logic [1:0] V_OK = 2'd0;
  localparam logic [1:0] V_BAD_CMD = 2'd1;
  localparam logic [1:0] V_CHECKSUM = 2'd2;
  localparam logic [1:0] V_LENGTH = 2'd3;

  typedef struct packed {
    logic [7:0] preamble_value;
    logic [7:0] command_limit;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } item_t;

endpackage

// File: sv/xcfr_regs.sv
// ----------------------------------------------------------------------------
// xcfr_regs
// APB register file: preamble value and command limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xcfr_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output xcfr_pkg::cfg_t      cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.preamble_value <= xcfr_pkg::PREAMBLE_RST;
      cfg.command_limit  <= xcfr_pkg::CMD_LIMIT_RST;
    end else if (wr_en) begin
      case (paddr[2])
        xcfr_pkg::REG_PREAMBLE:  cfg.preamble_value <= pwdata[7:0];
        xcfr_pkg::REG_CMD_LIMIT: cfg.command_limit  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      xcfr_pkg::REG_PREAMBLE:  prdata = {24'd0, cfg.preamble_value};
      xcfr_pkg::REG_CMD_LIMIT: prdata = {24'd0, cfg.command_limit};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

// File: sv/xcfr_in_stage.sv
// ----------------------------------------------------------------------------
// xcfr_in_stage
// Input register: holds one received byte until the core takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xcfr_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,
  input  logic                take,
  output xcfr_pkg::item_t     item
);

  assign s_tready = !item.valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (s_tready) begin
      item.valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      item.rx_byte <= s_tdata;
    end
  end

endmodule

// File: sv/xcfr_core.sv
// ----------------------------------------------------------------------------
// xcfr_core
// Frame state machine, XOR checksum and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xcfr_core #(
  parameter int MAX_FRAME_LEN = xcfr_pkg::MAX_FRAME_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  xcfr_pkg::cfg_t      cfg,
  input  xcfr_pkg::item_t     item,
  output logic                take,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [15:0]         m_tdata,
  output logic                m_tlast,
  output logic [1:0]          m_tuser
);

  localparam int POS_W = $clog2(MAX_FRAME_LEN);
  localparam logic [5:0] IDX_PREAMBLE = 6'd0;
  localparam logic [5:0] IDX_LENGTH = 6'd1;
  localparam logic [8:0] MAX_LEN_9 = 9'(MAX_FRAME_LEN);

  typedef enum logic [1:0] {
    HUNT,
    LEN,
    BODY
  } phase_t;

  phase_t           phase, phase_next;
  logic [POS_W-1:0] position, position_next;
  logic [POS_W-1:0] frame_length, frame_length_next;
  logic [7:0]       running_xor, running_xor_next;
  logic [7:0]       command_code, command_code_next;

  logic [7:0]       b;
  logic [POS_W-1:0] pos_inc;
  logic [7:0]       pos_w8;
  logic             len_bad;
  logic             last_hit;
  logic             emit;
  logic [5:0]       idx;
  logic             fend;
  logic [1:0]       verd;
  logic             out_free;

  logic [7:0]       obyte;
  logic [5:0]       oidx;
  logic             oend;
  logic [1:0]       overd;

  assign b        = item.rx_byte;
  assign pos_inc  = position + POS_W'(1);
  assign pos_w8   = 8'(pos_inc);
  assign len_bad  = (b < 8'd2) || ((9'(b) + 9'd2) > MAX_LEN_9);
  assign last_hit = {1'b0, pos_inc} >= ({1'b0, frame_length} + (POS_W+1)'(1));
  assign out_free = !m_tvalid || m_tready;
  assign take     = item.valid && (out_free || !emit);

  always_comb begin
    phase_next        = phase;
    position_next     = position;
    frame_length_next = frame_length;
    running_xor_next  = running_xor;
    command_code_next = command_code;
    emit              = 1'b0;
    idx               = IDX_PREAMBLE;
    fend              = 1'b0;
    verd              = xcfr_pkg::V_OK;
    case (phase)
      LEN: begin
        emit = 1'b1;
        idx  = IDX_LENGTH;
        if (len_bad) begin
          fend          = 1'b1;
          verd          = xcfr_pkg::V_LENGTH;
          phase_next    = HUNT;
          position_next = '0;
        end else begin
          frame_length_next = POS_W'(b);
          running_xor_next  = running_xor ^ b;
          position_next     = POS_W'(1);
          phase_next        = BODY;
        end
      end
      BODY: begin
        emit          = 1'b1;
        idx           = pos_w8[5:0];
        position_next = pos_inc;
        if (pos_inc == POS_W'(2)) begin
          command_code_next = b;
        end
        if (last_hit) begin
          fend = 1'b1;
          if (command_code_next >= cfg.command_limit) begin
            verd = xcfr_pkg::V_BAD_CMD;
          end else if (b != running_xor) begin
            verd = xcfr_pkg::V_CHECKSUM;
          end
          phase_next    = HUNT;
          position_next = '0;
        end else begin
          running_xor_next = running_xor ^ b;
        end
      end
      default: begin
        // hunting; the spare code behaves the same
        phase_next = HUNT;
        if (b == cfg.preamble_value) begin
          emit              = 1'b1;
          phase_next        = LEN;
          position_next     = '0;
          running_xor_next  = b;
          command_code_next = 8'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= HUNT;
      position     <= '0;
      frame_length <= '0;
      running_xor  <= 8'd0;
      command_code <= 8'd0;
      m_tvalid     <= 1'b0;
    end else begin
      if (take) begin
        phase        <= phase_next;
        position     <= position_next;
        frame_length <= frame_length_next;
        running_xor  <= running_xor_next;
        command_code <= command_code_next;
      end
      if (take && emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      obyte <= b;
      oidx  <= idx;
      oend  <= fend;
      overd <= verd;
    end
  end

  assign m_tdata = {2'b00, oidx, obyte};
  assign m_tlast = oend;
  assign m_tuser = overd;

endmodule

// File: sv/xor_checked_frame_receiver.sv
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver
// Hunts for a preamble, reads a length byte, passes the frame bytes through
// with their index and gives a command / checksum / length verdict at the end.
//
//   channel   dir  handshake          payload
//   s_*       in   tvalid/tready      tdata[7:0] rx_byte
//   m_*       out  tvalid/tready      tdata: frame_byte, byte_index; tlast; tuser
//   apb       in   psel/penable       paddr 0 preamble_value, 4 command_limit
//
// One item per cycle sustained while the output is not stalled; each result
// passes through the input register, then the result register.
// Bytes dropped while hunting give no result.
// Synchronous reset returns to hunting and empties both registers.
// With m_tready low the result holds, the input register fills, then s_tready
// drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xor_checked_frame_receiver #(
  parameter int MAX_FRAME_LEN = xcfr_pkg::MAX_FRAME_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] frame_byte, [13:8] byte_index, [15:14] zero
  output logic        m_tlast,   // frame_end
  output logic [1:0]  m_tuser,   // [1:0] verdict
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  xcfr_pkg::cfg_t  cfg;
  xcfr_pkg::item_t item;
  logic            take;

  xcfr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  xcfr_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .take     (take),
    .item     (item)
  );

  xcfr_core #(
    .MAX_FRAME_LEN (MAX_FRAME_LEN)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .item     (item),
    .take     (take),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// File: sv/xcfr_checker.sv
// ----------------------------------------------------------------------------
// xcfr_checker
// Port level assertions for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xcfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast,
  input logic [1:0]  m_tuser
);

  logic        bad_verdict;
  logic        len_verdict;
  logic        out_stall;
  logic [18:0] out_word;

  assign bad_verdict = m_tvalid && (m_tuser != xcfr_pkg::V_OK);
  assign len_verdict = m_tvalid && (m_tuser == xcfr_pkg::V_LENGTH);
  assign out_stall   = m_tvalid && !m_tready;
  assign out_word    = {m_tuser, m_tlast, m_tdata};

  `XCFR_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !m_tvalid, "result valid after reset")
  `XCFR_ASSERT(a_verdict_end, clk, rst, bad_verdict |-> m_tlast, "verdict without frame end")
  `XCFR_ASSERT(a_len_err_idx, clk, rst, len_verdict |-> (m_tdata[13:8] == 6'd1), "bad length idx")
  `XCFR_ASSERT(a_out_hold, clk, rst, out_stall |=> m_tvalid && $stable(out_word), "stall changed")

endmodule

bind xor_checked_frame_receiver xcfr_checker u_xcfr_checker (.*);
